/* rtl/psched_pkg.sv */
`timescale 1ns / 1ps
package psched_pkg;

    localparam int TASKS_DEF     = 8;
    localparam int TIME_BITS_DEF = 16;

    typedef enum logic [1:0] {
        REQ_LOAD = 2'd0,
        REQ_TICK = 2'd1,
        REQ_READ = 2'd2,
        REQ_NONE = 2'd3
    } t_req;

    typedef enum logic [2:0] {
        ST_RAN  = 3'd0,
        ST_IDLE = 3'd1,
        ST_PAST = 3'd2,
        ST_BAD  = 3'd3,
        ST_DONE = 3'd4
    } t_status;

    localparam logic [1:0] CFG_MODE    = 2'd0;
    localparam logic [1:0] CFG_COUNT   = 2'd1;
    localparam logic [1:0] CFG_HORIZON = 2'd2;

    typedef struct packed {
        t_req        req_type;
        logic [2:0]  task_index;
        logic [15:0] task_period;
        logic [15:0] task_burst;
    } t_in;

    typedef struct packed {
        t_status     status;
        logic [2:0]  ran_task;
        logic        completed;
        logic [7:0]  missed_mask;
        logic [7:0]  killed_mask;
        logic [15:0] miss_total;
        logic [15:0] done_total;
        logic [15:0] kill_total;
    } t_out;

    // One task table entry. phase holds the current time modulo the period.
    typedef struct packed {
        logic [15:0] period;
        logic [15:0] burst;
        logic [15:0] remain;
        logic [15:0] phase;
        logic [15:0] miss;
        logic [15:0] done;
        logic [15:0] kill;
    } t_rec;

    typedef struct packed {
        logic    capture;
        logic    rd_en;
        logic    rd_idx;
        logic    walk_init;
        logic    walk_proc;
        logic    kill_proc;
        logic    div_init;
        logic    div_step;
        logic    load_wr;
        logic    apply;
        logic    set_status;
        t_status status;
        logic    take_totals;
        logic    out_load;
    } t_cmd;

    typedef struct packed {
        t_req req;
        logic idx_ok;
        logic hz_reached;
        logic kill_cond;
        logic out_free;
    } t_sts;

    function automatic logic [15:0] sat_inc(input logic [15:0] v);
        return (v == 16'hFFFF) ? v : v + 16'd1;
    endfunction

endpackage

/* rtl/psched_ctrl.sv */
`timescale 1ns / 1ps
module psched_ctrl #(
    parameter int  TASKS     = 8,
    parameter int  TIME_BITS = 16,
    localparam int IDXW      = (TASKS > 1) ? $clog2(TASKS) : 1
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  psched_pkg::t_sts   i_sts,
    output psched_pkg::t_cmd   o_cmd,
    output logic [IDXW-1:0]    o_walk_addr
);
    import psched_pkg::*;

    localparam int CW_T = $clog2(TASKS + 1);
    localparam int CW_D = $clog2(TIME_BITS + 1);
    localparam int CNTW = (CW_T > CW_D) ? CW_T : CW_D;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DECODE,
        S_RDTOT,
        S_DIV,
        S_LOADWR,
        S_WALK,
        S_APPLY,
        S_KILL,
        S_DONE
    } t_state;

    t_state          r_state, n_state;
    logic [CNTW-1:0] r_cnt, n_cnt;
    logic            r_busy;
    t_cmd            cmd;

    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        cmd     = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    cmd.capture = 1'b1;
                    n_state     = S_DECODE;
                end
            end
            S_DECODE: begin
                n_cnt = '0;
                unique case (i_sts.req)
                    REQ_LOAD: begin
                        if (!i_sts.idx_ok) begin
                            cmd.set_status = 1'b1;
                            cmd.status     = ST_BAD;
                            n_state        = S_DONE;
                        end else begin
                            cmd.div_init = 1'b1;
                            n_state      = S_DIV;
                        end
                    end
                    REQ_READ: begin
                        if (!i_sts.idx_ok) begin
                            cmd.set_status = 1'b1;
                            cmd.status     = ST_BAD;
                            n_state        = S_DONE;
                        end else begin
                            cmd.rd_en  = 1'b1;
                            cmd.rd_idx = 1'b1;
                            n_state    = S_RDTOT;
                        end
                    end
                    REQ_TICK: begin
                        if (i_sts.hz_reached) begin
                            cmd.set_status = 1'b1;
                            cmd.status     = ST_PAST;
                            n_state        = S_DONE;
                        end else begin
                            cmd.walk_init = 1'b1;
                            n_state       = S_WALK;
                        end
                    end
                    default: begin
                        cmd.set_status = 1'b1;
                        cmd.status     = ST_BAD;
                        n_state        = S_DONE;
                    end
                endcase
            end
            S_RDTOT: begin
                cmd.take_totals = 1'b1;
                cmd.set_status  = 1'b1;
                cmd.status      = ST_DONE;
                n_state         = S_DONE;
            end
            S_DIV: begin
                cmd.div_step = 1'b1;
                n_cnt        = r_cnt + CNTW'(1);
                if (r_cnt == CNTW'(TIME_BITS - 1)) begin
                    n_state = S_LOADWR;
                end
            end
            S_LOADWR: begin
                cmd.load_wr    = 1'b1;
                cmd.set_status = 1'b1;
                cmd.status     = ST_DONE;
                n_state        = S_DONE;
            end
            S_WALK: begin
                // Read of entry k overlaps processing of entry k-1.
                cmd.rd_en     = (r_cnt < CNTW'(TASKS));
                cmd.walk_proc = (r_cnt != '0);
                n_cnt         = r_cnt + CNTW'(1);
                if (r_cnt == CNTW'(TASKS)) begin
                    n_state = S_APPLY;
                end
            end
            S_APPLY: begin
                cmd.apply = 1'b1;
                n_cnt     = '0;
                n_state   = i_sts.kill_cond ? S_KILL : S_DONE;
            end
            S_KILL: begin
                cmd.rd_en     = (r_cnt < CNTW'(TASKS));
                cmd.kill_proc = (r_cnt != '0);
                n_cnt         = r_cnt + CNTW'(1);
                if (r_cnt == CNTW'(TASKS)) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (i_sts.out_free) begin
                    cmd.out_load = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
            r_busy  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_busy  <= (n_state != S_IDLE);
        end
    end

    assign o_in_stall  = r_busy;
    assign o_cmd       = cmd;
    assign o_walk_addr = r_cnt[IDXW-1:0];

endmodule

/* rtl/psched_dp.sv */
`timescale 1ns / 1ps
module psched_dp #(
    parameter int  TASKS     = 8,
    parameter int  TIME_BITS = 16,
    localparam int IDXW      = (TASKS > 1) ? $clog2(TASKS) : 1
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  psched_pkg::t_in    i_in_data,
    input  logic               i_cfg_valid,
    input  logic [1:0]         i_cfg_index,
    input  logic [15:0]        i_cfg_data,
    input  logic               i_out_stall,
    output logic               o_out_valid,
    output psched_pkg::t_out   o_out_data,
    input  psched_pkg::t_cmd   i_cmd,
    input  logic [IDXW-1:0]    i_walk_addr,
    output psched_pkg::t_sts   o_sts
);
    import psched_pkg::*;

    localparam int CW = (TIME_BITS > 16) ? TIME_BITS : 16;

    // Configuration and global state.
    logic                 r_mode;
    logic [3:0]           r_tcount;
    logic [15:0]          r_horizon;
    logic [TIME_BITS-1:0] r_time;
    logic                 r_hz;

    // Request, result under construction and output register.
    t_in  r_req;
    t_out r_res;
    t_out r_out;
    logic r_out_valid;

    // Task table.
    t_rec            mem [TASKS];
    logic [TASKS-1:0] r_vld;
    t_rec            r_rd_data;
    logic            r_rd_vld;
    logic [IDXW-1:0] r_rd_addr;

    // Serial remainder unit and selection state.
    logic [15:0]          r_div_rem;
    logic [TIME_BITS-1:0] r_div_sh;
    logic                 r_found;
    logic [IDXW-1:0]      r_best;
    logic [15:0]          r_best_key;
    t_rec                 r_best_rec;

    logic [6:0]           act_n;
    logic [6:0]           addr7;
    logic                 idx_ok;
    logic                 in_use;
    t_rec                 eff;
    t_rec                 walk_rec;
    t_rec                 kill_rec;
    t_rec                 best_dec;
    t_rec                 ld_rec;
    logic                 released;
    logic                 missed;
    logic                 cand;
    logic                 take;
    logic                 kill_hit;
    logic                 best_done;
    logic [15:0]          phase_inc;
    logic [15:0]          key;
    logic [7:0]           mask_bit;
    logic [TIME_BITS-1:0] time_inc;
    logic                 kill_cond;
    logic [16:0]          div_t;
    logic [16:0]          div_n;
    logic                 wr_en;
    logic [IDXW-1:0]      wr_addr;
    t_rec                 wr_data;
    logic [IDXW-1:0]      rd_addr;

    assign act_n  = (7'(r_tcount) > 7'(TASKS)) ? 7'(TASKS) : 7'(r_tcount);
    assign idx_ok = (7'(r_req.task_index) < act_n);
    assign addr7  = 7'(r_rd_addr);
    assign in_use = (addr7 < act_n);
    assign eff    = r_rd_vld ? r_rd_data : '0;
    assign mask_bit = (addr7 < 7'd8) ? (8'd1 << addr7[2:0]) : 8'd0;

    // Release, miss check, phase advance and candidate key for one entry.
    always_comb begin
        released  = in_use && (eff.period != 16'd0) && (eff.phase == 16'd0);
        missed    = released && (eff.remain != 16'd0) && (r_time != '0);
        phase_inc = eff.phase + 16'd1;
        walk_rec  = eff;
        if (released) begin
            walk_rec.remain = eff.burst;
        end
        if (missed) begin
            walk_rec.miss = sat_inc(eff.miss);
        end
        walk_rec.phase = ((eff.period == 16'd0) || (phase_inc == eff.period)) ? 16'd0
                                                                               : phase_inc;
        key  = r_mode ? (eff.period - eff.phase) : eff.period;
        cand = in_use && (walk_rec.remain != 16'd0) && (eff.period != 16'd0);
        take = cand && (!r_found || (key < r_best_key));
    end

    always_comb begin
        kill_hit      = in_use && (eff.remain != 16'd0);
        kill_rec      = eff;
        kill_rec.kill = sat_inc(eff.kill);
    end

    always_comb begin
        best_dec        = r_best_rec;
        best_dec.remain = r_best_rec.remain - 16'd1;
        best_done       = (best_dec.remain == 16'd0);
        if (best_done) begin
            best_dec.done = sat_inc(r_best_rec.done);
        end
    end

    assign time_inc  = r_time + TIME_BITS'(1);
    assign kill_cond = (CW'(time_inc) >= CW'(r_horizon)) || (time_inc == '0);

    // One restoring step of time modulo period.
    assign div_t = {r_div_rem, r_div_sh[TIME_BITS-1]};
    assign div_n = (div_t >= {1'b0, r_req.task_period}) ? (div_t - {1'b0, r_req.task_period})
                                                         : div_t;

    always_comb begin
        ld_rec        = '0;
        ld_rec.period = r_req.task_period;
        ld_rec.burst  = r_req.task_burst;
        ld_rec.phase  = (r_req.task_period == 16'd0) ? 16'd0 : r_div_rem;
    end

    always_comb begin
        wr_en   = 1'b0;
        wr_addr = r_rd_addr;
        wr_data = walk_rec;
        if (i_cmd.load_wr) begin
            wr_en   = 1'b1;
            wr_addr = IDXW'(r_req.task_index);
            wr_data = ld_rec;
        end else if (i_cmd.walk_proc) begin
            wr_en   = r_rd_vld;
        end else if (i_cmd.apply) begin
            wr_en   = r_found;
            wr_addr = r_best;
            wr_data = best_dec;
        end else if (i_cmd.kill_proc) begin
            wr_en   = r_rd_vld && kill_hit;
            wr_data = kill_rec;
        end
    end

    assign rd_addr = i_cmd.rd_idx ? IDXW'(r_req.task_index) : i_walk_addr;

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (i_cmd.rd_en) begin
            r_rd_data <= mem[rd_addr];
            r_rd_vld  <= r_vld[rd_addr];
            r_rd_addr <= rd_addr;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode      <= 1'b0;
            r_tcount    <= 4'd1;
            r_horizon   <= 16'hFFFF;
            r_time      <= '0;
            r_hz        <= 1'b0;
            r_vld       <= '0;
            r_found     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                unique case (i_cfg_index)
                    CFG_MODE:    r_mode    <= i_cfg_data[0];
                    CFG_COUNT:   r_tcount  <= i_cfg_data[3:0];
                    CFG_HORIZON: r_horizon <= i_cfg_data;
                    default: begin
                    end
                endcase
            end
            if (i_cmd.apply) begin
                r_time <= time_inc;
                if (kill_cond) begin
                    r_hz <= 1'b1;
                end
            end
            if (i_cmd.load_wr) begin
                r_vld[IDXW'(r_req.task_index)] <= 1'b1;
            end
            if (i_cmd.walk_init) begin
                r_found <= 1'b0;
            end else if (i_cmd.walk_proc && take) begin
                r_found <= 1'b1;
            end
            if (i_cmd.out_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_req <= i_in_data;
            r_res <= '0;
        end
        if (i_cmd.set_status) begin
            r_res.status <= i_cmd.status;
        end
        if (i_cmd.take_totals) begin
            r_res.miss_total <= eff.miss;
            r_res.done_total <= eff.done;
            r_res.kill_total <= eff.kill;
        end
        if (i_cmd.div_init) begin
            r_div_rem <= '0;
            r_div_sh  <= r_time;
        end else if (i_cmd.div_step) begin
            r_div_rem <= div_n[15:0];
            r_div_sh  <= r_div_sh << 1;
        end
        if (i_cmd.walk_proc) begin
            if (missed) begin
                r_res.missed_mask <= r_res.missed_mask | mask_bit;
            end
            if (take) begin
                r_best     <= r_rd_addr;
                r_best_key <= key;
                r_best_rec <= walk_rec;
            end
        end
        if (i_cmd.apply) begin
            if (r_found) begin
                r_res.status    <= ST_RAN;
                r_res.ran_task  <= 3'(r_best);
                r_res.completed <= best_done;
            end else begin
                r_res.status    <= ST_IDLE;
            end
        end
        if (i_cmd.kill_proc && kill_hit) begin
            r_res.killed_mask <= r_res.killed_mask | mask_bit;
        end
        if (i_cmd.out_load) begin
            r_out <= r_res;
        end
    end

    always_comb begin
        o_sts.req        = r_req.req_type;
        o_sts.idx_ok     = idx_ok;
        o_sts.hz_reached = r_hz;
        o_sts.kill_cond  = kill_cond;
        o_sts.out_free   = !r_out_valid || !i_out_stall;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

/* rtl/periodic_task_scheduler_rm_edf_unit.sv */
`timescale 1ns / 1ps
// Periodic task scheduler, rate monotonic or earliest deadline first, one time unit per tick
// transaction. The task table is a single memory walked one entry per cycle, and the tick that
// reaches the horizon adds a second walk to count killed tasks. Each entry keeps the current
// time modulo its period, so a load computes that remainder with a serial unit at one bit per
// cycle. One transaction is in progress at a time; the input is stalled until its result is
// handed to the output register, which holds one finished result while the next transaction
// starts. Configuration writes are always ready.
module periodic_task_scheduler_rm_edf_unit #(
    parameter int TASKS     = psched_pkg::TASKS_DEF,
    parameter int TIME_BITS = psched_pkg::TIME_BITS_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_stall,
    input  psched_pkg::t_in  i_in_data,
    output logic             o_out_valid,
    input  logic             i_out_stall,
    output psched_pkg::t_out o_out_data,
    input  logic             i_cfg_valid,
    output logic             o_cfg_ready,
    input  logic [1:0]       i_cfg_index,
    input  logic [15:0]      i_cfg_data
);
    import psched_pkg::*;

    localparam int IDXW = (TASKS > 1) ? $clog2(TASKS) : 1;

    t_cmd            cmd;
    t_sts            sts;
    logic [IDXW-1:0] walk_addr;

    assign o_cfg_ready = 1'b1;

    psched_ctrl #(
        .TASKS     (TASKS),
        .TIME_BITS (TIME_BITS)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_sts       (sts),
        .o_cmd       (cmd),
        .o_walk_addr (walk_addr)
    );

    psched_dp #(
        .TASKS     (TASKS),
        .TIME_BITS (TIME_BITS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_data   (i_in_data),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_out_stall (i_out_stall),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data),
        .i_cmd       (cmd),
        .i_walk_addr (walk_addr),
        .o_sts       (sts)
    );

endmodule

/* rtl/psched_chk.sv */
`timescale 1ns / 1ps
module psched_chk (
    input logic             i_clk,
    input logic             i_rst_n,
    input logic             i_in_valid,
    input logic             o_in_stall,
    input logic             o_out_valid,
    input logic             i_out_stall,
    input psched_pkg::t_out o_out_data
);
    import psched_pkg::*;

    // A transaction occupies the block, so input must stall right after acceptance.
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("input not stalled after an accepted transaction");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> (o_out_valid && $stable(o_out_data)))
        else $error("stalled result changed or dropped");

    a_ran_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_out_data.status != ST_RAN))
        |-> ((o_out_data.ran_task == 3'd0) && !o_out_data.completed))
        else $error("task fields set on a result that ran no task");

    a_mask_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && ((o_out_data.status == ST_PAST) || (o_out_data.status == ST_BAD)
                         || (o_out_data.status == ST_DONE)))
        |-> ((o_out_data.missed_mask == 8'd0) && (o_out_data.killed_mask == 8'd0)))
        else $error("miss or kill mask set on a non-tick result");

    a_total_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_out_data.status != ST_DONE))
        |-> ((o_out_data.miss_total == 16'd0) && (o_out_data.done_total == 16'd0)
             && (o_out_data.kill_total == 16'd0)))
        else $error("counter totals set on a result that is not a read");

endmodule

bind periodic_task_scheduler_rm_edf_unit psched_chk u_psched_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_stall  (o_in_stall),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out_data  (o_out_data)
);
